// File: hw/rtl/tlbe_pkg.sv
// shared constants, types and cordic helpers for the target lock bearing error core
package tlbe_pkg;

   // cordic configuration
   localparam int CORDIC_STEPS = 16;
   localparam int STEPS_PER_STAGE = 2;
   localparam int NUM_STAGES = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // datapath widths
   localparam int FIELD_W = 16;
   localparam int XY_W = 26;            // scaled position plus cordic gain headroom
   localparam int Z_W = 25;             // angle in 2^-20 rad
   localparam int POS_SCALE = 8;        // inputs scaled by 2^8
   localparam int ANG_FRAC = 20;
   localparam int ANG_SHIFT = ANG_FRAC - 13;
   localparam int ANG_ROUND = 1 << (ANG_FRAC - 14);
   localparam int PI_Z = 3294199;
   localparam int ANG_MAX = 25736;

   // operation codes
   localparam logic [1:0] OP_TRACK = 2'd0;
   localparam logic [1:0] OP_EMPTY = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CONF_THR = 2'd0;
   localparam logic [1:0] REG_HEIGHT_THR = 2'd1;
   localparam logic [1:0] REG_TIMEOUT = 2'd2;

   // register reset values
   localparam logic [FIELD_W-1:0] CONF_THR_RESET = 16'd282;
   localparam logic [FIELD_W-1:0] HEIGHT_THR_RESET = 16'd358;
   localparam logic [FIELD_W-1:0] TIMEOUT_RESET = 16'd3000;

   // result fields that ride alongside the angle through the pipeline
   typedef struct packed {
      logic                error_valid;
      logic                locked;
      logic [FIELD_W-1:0]  locked_target;
      logic                lock_dropped;
   } side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

   function automatic logic signed [Z_W-1:0] atan_val(input int unsigned i);
      logic signed [Z_W-1:0] r;
      case (i)
         0:       r = Z_W'(823550);
         1:       r = Z_W'(486170);
         2:       r = Z_W'(256879);
         3:       r = Z_W'(130396);
         4:       r = Z_W'(65451);
         5:       r = Z_W'(32757);
         6:       r = Z_W'(16383);
         7:       r = Z_W'(8192);
         8:       r = Z_W'(4096);
         9:       r = Z_W'(2048);
         10:      r = Z_W'(1024);
         11:      r = Z_W'(512);
         12:      r = Z_W'(256);
         13:      r = Z_W'(128);
         14:      r = Z_W'(64);
         15:      r = Z_W'(32);
         16:      r = Z_W'(16);
         17:      r = Z_W'(8);
         18:      r = Z_W'(4);
         19:      r = Z_W'(2);
         20:      r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // one vectoring iteration, shifts round toward minus infinity
   function automatic vec_type cordic_step(input vec_type v, input int unsigned i);
      vec_type r;
      logic signed [XY_W-1:0] sx;
      logic signed [XY_W-1:0] sy;
      sx = v.x >>> i;
      sy = v.y >>> i;
      if (!v.y[XY_W-1]) begin
         r.x = v.x + sy;
         r.y = v.y - sx;
         r.z = v.z + atan_val(i);
      end else begin
         r.x = v.x - sy;
         r.y = v.y + sx;
         r.z = v.z - atan_val(i);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/tlbe_cordic.sv
// pipelined vectoring cordic for atan2 with sideband result fields
module tlbe_cordic
   import tlbe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [FIELD_W-1:0]  in_x,
   input  logic signed [FIELD_W-1:0]  in_y,
   input  side_type                   in_side,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [FIELD_W-1:0]  out_angle,
   output side_type                   out_side
);

   vec_type  vec_ff [NUM_STAGES+1];
   side_type side_ff [NUM_STAGES+1];
   logic     zero_ff [NUM_STAGES+1];
   logic     valid_ff [NUM_STAGES+1];
   logic     move [NUM_STAGES+1];

   logic                       out_valid_ff;
   logic signed [FIELD_W-1:0]  angle_ff;
   side_type                   out_side_ff;
   logic                       move_out;

   // setup: fold the left half plane onto the right with a pi start angle
   vec_type                 setup_vec;
   logic signed [XY_W-1:0]  px_w;
   logic signed [XY_W-1:0]  py_w;
   logic                    neg;

   always_comb begin
      px_w = XY_W'(in_x);
      py_w = XY_W'(in_y);
      neg = in_x[FIELD_W-1];
      if (neg) begin
         setup_vec.x = (-px_w) <<< POS_SCALE;
         setup_vec.y = (-py_w) <<< POS_SCALE;
         setup_vec.z = in_y[FIELD_W-1] ? -Z_W'(PI_Z) : Z_W'(PI_Z);
      end else begin
         setup_vec.x = px_w <<< POS_SCALE;
         setup_vec.y = py_w <<< POS_SCALE;
         setup_vec.z = '0;
      end
   end

   // ready ripples back from the output register
   assign move_out = !out_valid_ff || out_ready;

   always_comb begin
      move[NUM_STAGES] = !valid_ff[NUM_STAGES] || move_out;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   assign in_ready = move[0];

   // next value of every stage: stage 0 takes the setup vector, the others STEPS_PER_STAGE iterations each
   vec_type  nxt_vec [NUM_STAGES+1];
   side_type side_src [NUM_STAGES+1];
   logic     zero_src [NUM_STAGES+1];
   logic     valid_src [NUM_STAGES+1];

   always_comb begin
      vec_type v;
      int      step;
      nxt_vec[0] = setup_vec;
      side_src[0] = in_side;
      zero_src[0] = (in_x == '0) && (in_y == '0);
      valid_src[0] = in_valid;
      for (int k = 1; k <= NUM_STAGES; k++) begin
         v = vec_ff[k-1];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            step = (k - 1) * STEPS_PER_STAGE + s;
            if (step < CORDIC_STEPS) begin
               v = cordic_step(v, unsigned'(step));
            end
         end
         nxt_vec[k] = v;
         side_src[k] = side_ff[k-1];
         zero_src[k] = zero_ff[k-1];
         valid_src[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NUM_STAGES; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (move[k]) begin
            valid_ff[k] <= valid_src[k];
         end
         if (move[k]) begin
            vec_ff[k] <= nxt_vec[k];
            side_ff[k] <= side_src[k];
            zero_ff[k] <= zero_src[k];
         end
      end
   end

   // round to nearest q3.13, halves up, then saturate; zero when no error is valid or the input was the origin
   logic signed [Z_W-1:0] z_rnd;
   logic signed [FIELD_W-1:0] angle_in;

   always_comb begin
      z_rnd = (vec_ff[NUM_STAGES].z + Z_W'(ANG_ROUND)) >>> ANG_SHIFT;
      if (z_rnd > Z_W'(ANG_MAX)) begin
         angle_in = FIELD_W'(ANG_MAX);
      end else if (z_rnd < -Z_W'(ANG_MAX)) begin
         angle_in = -FIELD_W'(ANG_MAX);
      end else begin
         angle_in = z_rnd[FIELD_W-1:0];
      end
      if (!side_ff[NUM_STAGES].error_valid || zero_ff[NUM_STAGES]) begin
         angle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move_out) begin
         out_valid_ff <= valid_ff[NUM_STAGES];
      end
      if (move_out) begin
         angle_ff <= angle_in;
         out_side_ff <= side_ff[NUM_STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;
   assign out_side = out_side_ff;

endmodule

// File: hw/rtl/target_lock_bearing_error_core.sv
// top level: target lock tracking and bearing error output
// Takes one beat per cycle: a track entry, an empty-frame marker or a time tick. Track
// entries and ticks update the lock state in the cycle they are taken; a beat that ends a
// frame (an entry flagged last, or an empty frame) also yields one result beat carrying
// the bearing error atan2(y, x) in q3.13 radians, the lock state after the frame, the
// locked id and a timeout-drop flag. The atan2 runs in a cordic pipeline of two iterations
// per stage, behind a setup register and ahead of an output register; the pipeline holds
// CORDIC_STEPS/2 + 2 results, and the input stalls only when it is full and the result
// side is stalled. Sustained rate is one beat per cycle while the result side is not
// stalled.
module target_lock_bearing_error_core
   import tlbe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input beats
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [FIELD_W-1:0]         req_track_id,
   input  logic signed [FIELD_W-1:0]  req_pos_x,
   input  logic signed [FIELD_W-1:0]  req_pos_y,
   input  logic signed [FIELD_W-1:0]  req_confidence,
   input  logic signed [FIELD_W-1:0]  req_height,
   input  logic                       req_last_in_frame,
   // result beats
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_error_valid,
   output logic signed [FIELD_W-1:0]  rsp_angle_error,
   output logic                       rsp_locked,
   output logic [FIELD_W-1:0]         rsp_locked_target,
   output logic                       rsp_lock_dropped,
   // register writes
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [FIELD_W-1:0]         csr_data
);

   // configuration registers
   logic signed [FIELD_W-1:0] conf_thr_ff;
   logic signed [FIELD_W-1:0] height_thr_ff;
   logic [FIELD_W-1:0]        timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_thr_ff <= CONF_THR_RESET;
         height_thr_ff <= HEIGHT_THR_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CONF_THR:   conf_thr_ff <= csr_data;
            REG_HEIGHT_THR: height_thr_ff <= csr_data;
            REG_TIMEOUT:    timeout_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   // lock and per-frame state
   logic                lock_ff, lock_in;
   logic [FIELD_W-1:0]  lock_id_ff, lock_id_in;
   logic [FIELD_W-1:0]  unseen_ff, unseen_in;
   logic                began_locked_ff, began_locked_in;
   logic                chosen_ff, chosen_in;
   logic [FIELD_W-1:0]  chosen_id_ff, chosen_id_in;
   logic [FIELD_W-1:0]  chosen_x_ff, chosen_x_in;
   logic [FIELD_W-1:0]  chosen_y_ff, chosen_y_in;

   logic      cor_ready;
   logic      accept;
   logic      is_track;
   logic      ends_frame;
   logic      pick;
   side_type  side;

   assign req_stall = !cor_ready;
   assign accept = req_valid && !req_stall;
   assign is_track = (req_operation == OP_TRACK);
   // beat that closes a frame and so produces a result
   assign ends_frame = (req_operation == OP_EMPTY) || (is_track && req_last_in_frame);

   always_comb begin
      lock_in = lock_ff;
      lock_id_in = lock_id_ff;
      unseen_in = unseen_ff;
      began_locked_in = began_locked_ff;
      chosen_in = chosen_ff;
      chosen_id_in = chosen_id_ff;
      chosen_x_in = chosen_x_ff;
      chosen_y_in = chosen_y_ff;
      side = '0;
      pick = 1'b0;

      // unlocked: last qualifying entry wins; locked: first entry with the locked id
      if (is_track) begin
         if (!began_locked_ff) begin
            pick = (req_confidence > conf_thr_ff) && (req_height > height_thr_ff);
         end else begin
            pick = !chosen_ff && (req_track_id == lock_id_ff);
         end
      end

      if (accept) begin
         if (req_operation == OP_TICK) begin
            if (unseen_ff != '1) begin
               unseen_in = unseen_ff + FIELD_W'(1);
            end
         end

         if (pick) begin
            chosen_in = 1'b1;
            chosen_id_in = req_track_id;
            chosen_x_in = req_pos_x;
            chosen_y_in = req_pos_y;
         end

         if (ends_frame) begin
            if (chosen_in) begin
               if (!lock_ff) begin
                  lock_in = 1'b1;
                  lock_id_in = chosen_id_in;
               end
               unseen_in = '0;
               side.error_valid = 1'b1;
            end else if (unseen_ff > timeout_ff) begin
               // timeout; flagged only when a lock was actually held
               side.lock_dropped = lock_ff;
               lock_in = 1'b0;
            end
            chosen_in = 1'b0;
            began_locked_in = lock_in;
         end
      end

      side.locked = lock_in;
      side.locked_target = lock_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= 1'b0;
         lock_id_ff <= '0;
         unseen_ff <= '0;
         began_locked_ff <= 1'b0;
         chosen_ff <= 1'b0;
         chosen_id_ff <= '0;
         chosen_x_ff <= '0;
         chosen_y_ff <= '0;
      end else begin
         lock_ff <= lock_in;
         lock_id_ff <= lock_id_in;
         unseen_ff <= unseen_in;
         began_locked_ff <= began_locked_in;
         chosen_ff <= chosen_in;
         chosen_id_ff <= chosen_id_in;
         chosen_x_ff <= chosen_x_in;
         chosen_y_ff <= chosen_y_in;
      end
   end

   // the chosen position for this frame, including a pick on the closing beat itself
   logic signed [FIELD_W-1:0] frame_x;
   logic signed [FIELD_W-1:0] frame_y;

   assign frame_x = pick ? req_pos_x : chosen_x_ff;
   assign frame_y = pick ? req_pos_y : chosen_y_ff;

   side_type rsp_side;

   tlbe_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && ends_frame),
      .in_ready  (cor_ready),
      .in_x      (frame_x),
      .in_y      (frame_y),
      .in_side   (side),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_angle (rsp_angle_error),
      .out_side  (rsp_side)
   );

   assign rsp_error_valid = rsp_side.error_valid;
   assign rsp_locked = rsp_side.locked;
   assign rsp_locked_target = rsp_side.locked_target;
   assign rsp_lock_dropped = rsp_side.lock_dropped;

endmodule
